// ----- hw/rtl/apq_pkg.sv -----
// ----------------------------------------------------------------------------
// apq_pkg
// Shared types and constants of the adaptive palette quantizer.
// ----------------------------------------------------------------------------
package apq_pkg;

   localparam int INDEX_W = 8;
   localparam int STATUS_W = 2;
   localparam int COLOR_W = 16;
   localparam int CHAN_W = 8;

   localparam logic [STATUS_W-1:0] STATUS_FOUND = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ADDED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   localparam logic [INDEX_W-1:0] OVERFLOW_INDEX = 8'd255;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_COMPARE,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // take a new pixel, restart the search
      logic read;      // read palette entry at the current slot
      logic step;      // advance to the next slot
      logic set_hit;   // current entry matched
      logic finish;    // load the result register, append on a miss if not full
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic count_zero;  // palette holds no entries
      logic match;       // entry read last cycle equals the color
      logic last_slot;   // current slot is the last filled one
      logic out_free;    // result register can take a new result
   } status_type;

   function automatic logic [COLOR_W-1:0] pack565(
      input logic [CHAN_W-1:0] r,
      input logic [CHAN_W-1:0] g,
      input logic [CHAN_W-1:0] b
   );
      return {r[7:3], g[7:2], b[7:3]};
   endfunction

endpackage

// ----- hw/rtl/apq_controller.sv -----
// ----------------------------------------------------------------------------
// apq_controller
// Sequencer for the palette search: accept, scan entries, finish.
// ----------------------------------------------------------------------------
module apq_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  apq_pkg::status_type status,
   output apq_pkg::cmd_type    cmd
);

   apq_pkg::state_type state_ff;
   apq_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= apq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         apq_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (status.count_zero) begin
                  state_in = apq_pkg::ST_FINISH;
               end else begin
                  state_in = apq_pkg::ST_READ;
               end
            end
         end
         apq_pkg::ST_READ: begin
            state_in = apq_pkg::ST_COMPARE;
         end
         apq_pkg::ST_COMPARE: begin
            if (status.match || status.last_slot) begin
               state_in = apq_pkg::ST_FINISH;
            end else begin
               state_in = apq_pkg::ST_READ;
            end
         end
         apq_pkg::ST_FINISH: begin
            if (status.out_free) begin
               state_in = apq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = apq_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_tready  = 1'b0;
      cmd         = '0;
      case (state_ff)
         apq_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         apq_pkg::ST_READ: begin
            cmd.read = 1'b1;
         end
         apq_pkg::ST_COMPARE: begin
            cmd.set_hit = status.match;
            cmd.step    = !status.match && !status.last_slot;
         end
         apq_pkg::ST_FINISH: begin
            cmd.finish = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ----- hw/rtl/apq_datapath.sv -----
// ----------------------------------------------------------------------------
// apq_datapath
// Palette memory, fill count, search slot and the result register.
// ----------------------------------------------------------------------------
module apq_datapath #(
   parameter int PALETTE_SIZE = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  apq_pkg::cmd_type                    cmd,
   output apq_pkg::status_type                 status,
   input  logic [apq_pkg::CHAN_W-1:0]          red,
   input  logic [apq_pkg::CHAN_W-1:0]          green,
   input  logic [apq_pkg::CHAN_W-1:0]          blue,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [apq_pkg::INDEX_W-1:0]         palette_index,
   output logic [apq_pkg::STATUS_W-1:0]        lookup_status,
   output logic [apq_pkg::COLOR_W-1:0]         packed_color
);

   localparam int AW = $clog2(PALETTE_SIZE);
   localparam int CW = $clog2(PALETTE_SIZE + 1);
   localparam logic [CW-1:0] SIZE_C = CW'(PALETTE_SIZE);

   logic [apq_pkg::COLOR_W-1:0] palette_mem [PALETTE_SIZE];

   logic [apq_pkg::COLOR_W-1:0]  color_ff;
   logic [apq_pkg::COLOR_W-1:0]  rdata_ff;
   logic [CW-1:0]                slot_ff;
   logic [CW-1:0]                slot_in;
   logic [CW-1:0]                count_ff;
   logic [CW-1:0]                count_in;
   logic                         hit_ff;
   logic                         hit_in;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic [apq_pkg::INDEX_W-1:0]  index_ff;
   logic [apq_pkg::INDEX_W-1:0]  index_in;
   logic [apq_pkg::STATUS_W-1:0] lstatus_ff;
   logic [apq_pkg::STATUS_W-1:0] lstatus_in;
   logic [apq_pkg::COLOR_W-1:0]  out_color_ff;
   logic [CW-1:0]                slot_next;
   logic                         full;
   logic                         append;
   logic [8:0]                   slot_wide;
   logic [8:0]                   count_wide;

   assign slot_next  = slot_ff + CW'(1);
   assign full       = (count_ff == SIZE_C);
   assign append     = cmd.finish && !hit_ff && !full;
   assign slot_wide  = 9'(slot_ff);
   assign count_wide = 9'(count_ff);

   assign status.count_zero = (count_ff == '0);
   assign status.match      = (rdata_ff == color_ff);
   assign status.last_slot  = (slot_next == count_ff);
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

   // palette memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (append) begin
         palette_mem[count_ff[AW-1:0]] <= color_ff;
      end
      if (cmd.read) begin
         rdata_ff <= palette_mem[slot_ff[AW-1:0]];
      end
   end

   always_comb begin
      slot_in = slot_ff;
      hit_in  = hit_ff;
      if (cmd.load) begin
         slot_in = '0;
         hit_in  = 1'b0;
      end else begin
         if (cmd.step) begin
            slot_in = slot_next;
         end
         if (cmd.set_hit) begin
            hit_in = 1'b1;
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (append) begin
         count_in = count_ff + CW'(1);
      end
   end

   always_comb begin
      if (hit_ff) begin
         index_in   = slot_wide[apq_pkg::INDEX_W-1:0];
         lstatus_in = apq_pkg::STATUS_FOUND;
      end else if (!full) begin
         index_in   = count_wide[apq_pkg::INDEX_W-1:0];
         lstatus_in = apq_pkg::STATUS_ADDED;
      end else begin
         index_in   = apq_pkg::OVERFLOW_INDEX;
         lstatus_in = apq_pkg::STATUS_FULL;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      hit_ff  <= hit_in;
      if (cmd.load) begin
         color_ff <= apq_pkg::pack565(red, green, blue);
      end
      if (cmd.finish) begin
         index_ff     <= index_in;
         lstatus_ff   <= lstatus_in;
         out_color_ff <= color_ff;
      end
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign palette_index = index_ff;
   assign lookup_status = lstatus_ff;
   assign packed_color  = out_color_ff;

endmodule

// ----- hw/rtl/adaptive_palette_quantizer.sv -----
// ----------------------------------------------------------------------------
// adaptive_palette_quantizer
// RGB888 pixel to RGB565 palette index with on-the-fly palette growth.
// ----------------------------------------------------------------------------
// Each pixel is cut to RGB565 and looked up in a palette that keeps its
// contents across frames; the lowest matching slot is returned, a new color
// is appended at the next free slot, and a full palette returns slot 255
// with overflow status. The palette sits in a memory with one read port and
// is scanned one entry at a time, each entry passing a read state and a
// compare state; an empty palette skips the scan. A pixel finishes only when
// the previous result has left the output register, and the next pixel is
// taken after that. Reset empties the palette at once through the fill
// count; no clearing pass follows. A finished result waits in an output
// register, and the next pixel is taken meanwhile.
// ----------------------------------------------------------------------------
module adaptive_palette_quantizer #(
   parameter int PALETTE_SIZE = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red[7:0], green[15:8], blue[23:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // palette_index[7:0], lookup_status[9:8],
                                    // packed_color[25:10], zero[31:26]
);

   apq_pkg::cmd_type    cmd;
   apq_pkg::status_type status;

   logic [apq_pkg::INDEX_W-1:0]  palette_index;
   logic [apq_pkg::STATUS_W-1:0] lookup_status;
   logic [apq_pkg::COLOR_W-1:0]  packed_color;

   apq_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   apq_datapath #(
      .PALETTE_SIZE (PALETTE_SIZE)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .red           (req_tdata[7:0]),
      .green         (req_tdata[15:8]),
      .blue          (req_tdata[23:16]),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .palette_index (palette_index),
      .lookup_status (lookup_status),
      .packed_color  (packed_color)
   );

   assign rsp_tdata = {6'b0, packed_color, lookup_status, palette_index};

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken again right after a transfer");

   a_overflow_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (lookup_status == apq_pkg::STATUS_FULL)
         |-> (palette_index == apq_pkg::OVERFLOW_INDEX))
      else $error("overflow result without overflow index");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (lookup_status != apq_pkg::STATUS_FULL)
         |-> (9'(palette_index) < 9'(PALETTE_SIZE)))
      else $error("palette index beyond palette size");
`endif

endmodule
